@@ rtl/lspg_pkg.sv @@
// Shared types, widths and the spring slot tables of the lattice spring pair generator.
`default_nettype none
package lspg_pkg;

   localparam int MAX_SIDE    = 64;
   localparam int SIZE_W      = 7;
   localparam int COORD_W     = 6;
   localparam int IDX_W       = 18;
   localparam int SXY_W       = 13;
   localparam int YSZ_W       = 13;
   localparam int SLOT_COUNT  = 13;
   localparam int SLOT_W      = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int CSR_IDX_W   = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z = 2'd2;

   // offsets are {dx, dy, dz}
   localparam logic [2:0] OFF_000 = 3'b000;
   localparam logic [2:0] OFF_001 = 3'b001;
   localparam logic [2:0] OFF_010 = 3'b010;
   localparam logic [2:0] OFF_011 = 3'b011;
   localparam logic [2:0] OFF_100 = 3'b100;
   localparam logic [2:0] OFF_101 = 3'b101;
   localparam logic [2:0] OFF_110 = 3'b110;
   localparam logic [2:0] OFF_111 = 3'b111;

   typedef struct packed {
      logic [IDX_W-1:0]      base;
      logic [SIZE_W-1:0]     sz;
      logic [SXY_W-1:0]      sxy;
      logic [SLOT_COUNT-1:0] mask;
   } entry_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
      clamp_size = (s > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : s;
   endfunction

   // first endpoint offset of each spring slot
   function automatic logic [2:0] slot_a_off(input logic [SLOT_W-1:0] slot);
      case (slot)
         4'd7, 4'd8, 4'd9: slot_a_off = OFF_001;
         4'd10:            slot_a_off = OFF_101;
         4'd11:            slot_a_off = OFF_011;
         4'd12:            slot_a_off = OFF_010;
         default:          slot_a_off = OFF_000;
      endcase
   endfunction

   // second endpoint offset of each spring slot
   function automatic logic [2:0] slot_b_off(input logic [SLOT_W-1:0] slot);
      case (slot)
         4'd0:         slot_b_off = OFF_001;
         4'd1:         slot_b_off = OFF_010;
         4'd2:         slot_b_off = OFF_011;
         4'd3:         slot_b_off = OFF_100;
         4'd4:         slot_b_off = OFF_101;
         4'd5:         slot_b_off = OFF_110;
         4'd6:         slot_b_off = OFF_111;
         4'd7:         slot_b_off = OFF_010;
         4'd8:         slot_b_off = OFF_100;
         4'd9:         slot_b_off = OFF_110;
         4'd10:        slot_b_off = OFF_010;
         4'd11, 4'd12: slot_b_off = OFF_100;
         default:      slot_b_off = OFF_000;
      endcase
   endfunction

   // whether a slot exists for a node, given which axes are not on their last plane
   function automatic logic slot_enable(input logic [SLOT_W-1:0] slot,
                                        input logic xm, input logic ym, input logic zm);
      logic [2:0] o;
      o = slot_b_off(slot);
      case (slot)
         4'd7:                slot_enable = zm & ym;
         4'd8:                slot_enable = zm & xm;
         4'd9, 4'd10, 4'd11:  slot_enable = zm & ym & xm;
         4'd12:               slot_enable = ym & xm;
         default: begin
            if (slot < SLOT_W'(7)) begin
               slot_enable = (~o[2] | xm) & (~o[1] | ym) & (~o[0] | zm);
            end else begin
               slot_enable = 1'b0;
            end
         end
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] node_index(input logic [IDX_W-1:0] base,
                                                   input logic [SIZE_W-1:0] sz,
                                                   input logic [SXY_W-1:0] sxy,
                                                   input logic [2:0] off);
      logic [IDX_W-1:0] dz_term;
      logic [IDX_W-1:0] dy_term;
      logic [IDX_W-1:0] dx_term;
      dz_term = IDX_W'(off[0]);
      dy_term = off[1] ? IDX_W'(sz) : '0;
      dx_term = off[2] ? IDX_W'(sxy) : '0;
      node_index = base + dz_term + dy_term + dx_term;
   endfunction

endpackage
`default_nettype wire

@@ rtl/lspg_if.sv @@
// Valid/ready channel interfaces for node items and spring pair items.
`default_nettype none
interface lspg_req_if;
   logic                        valid;
   logic                        ready;
   logic [lspg_pkg::COORD_W-1:0] node_x;
   logic [lspg_pkg::COORD_W-1:0] node_y;
   logic [lspg_pkg::COORD_W-1:0] node_z;
   modport source (output valid, output node_x, output node_y, output node_z, input ready);
   modport sink   (input valid, input node_x, input node_y, input node_z, output ready);
endinterface

interface lspg_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lspg_pkg::IDX_W-1:0] first_index;
   logic [lspg_pkg::IDX_W-1:0] second_index;
   logic                      last_pair;
   modport source (output valid, output first_index, output second_index,
                   output last_pair, input ready);
   modport sink   (input valid, input first_index, input second_index,
                   input last_pair, output ready);
endinterface
`default_nettype wire

@@ rtl/lattice_spring_pair_generator_top.sv @@
// Top level of the lattice spring pair generator.
//
// Usage:
//  - csr_*: plain write port. Index 0/1/2 sets size_x/size_y/size_z (7 bits,
//    sizes above 64 act as 64). Write only while the block is idle.
//  - req_chan: one node (node_x, node_y, node_z) per item, valid/ready.
//  - rsp_chan: one spring pair per item; last_pair marks the node's final pair.
//    Nodes outside the lattice or owning no springs produce nothing.
// Timing:
//  - An accepted node passes the two front stages and the node queue before
//    the back end emits its pairs, one pair per cycle while rsp_chan.ready is
//    high (1 to 13 per node); a queued next node's pairs follow with no gap.
//  - The front end takes a node per cycle while the 4-deep node queue
//    has room; the queue decouples front and back.
// Reset: sizes return to 1, queue and pipeline empty, rsp_chan.valid low.
// Stall: while rsp_chan.ready is low the current pair holds; the queue fills
//  and req_chan.ready drops once it plus the two front stages reach 4 nodes.
`default_nettype none
module lattice_spring_pair_generator_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [lspg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lspg_pkg::SIZE_W-1:0]    csr_wr_data,
   lspg_req_if.sink                            req_chan,
   lspg_rsp_if.source                          rsp_chan
);

   logic                          push_valid;
   lspg_pkg::entry_type           push_entry;
   logic                          pop;
   logic                          head_valid;
   lspg_pkg::entry_type           head_entry;
   logic [lspg_pkg::QCNT_W-1:0]   q_count;

   // bounds check, slot mask, base index
   lspg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req         (req_chan),
      .q_count     (q_count),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   // node queue; the front reserves space before accepting, so push never overflows
   lspg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .count      (q_count)
   );

   // pair walker and result register
   lspg_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (head_valid),
      .q_head  (head_entry),
      .pop     (pop),
      .rsp     (rsp_chan)
   );

endmodule
`default_nettype wire

@@ rtl/lspg_front.sv @@
// Front end: size registers, node accept, bounds check, slot mask and base index.
`default_nettype none
module lspg_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [lspg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lspg_pkg::SIZE_W-1:0]       csr_wr_data,
   lspg_req_if.sink                               req,
   input  wire logic [lspg_pkg::QCNT_W-1:0]       q_count,
   output logic                                   push_valid,
   output lspg_pkg::entry_type                    push_entry
);

   logic [lspg_pkg::SIZE_W-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [lspg_pkg::SXY_W-1:0]   sxy_ff, sxy_in;
   logic [lspg_pkg::SIZE_W-1:0]  sx, sy, sz;

   logic                         a_valid_ff;
   logic [lspg_pkg::COORD_W-1:0] a_x_ff, a_y_ff, a_z_ff;

   logic                         b_valid_ff, b_valid_in;
   logic [lspg_pkg::COORD_W-1:0] b_x_ff, b_z_ff;
   logic [lspg_pkg::YSZ_W-1:0]   b_ysz_ff, b_ysz_in;
   logic [lspg_pkg::SIZE_W-1:0]  b_sz_ff;
   logic [lspg_pkg::SLOT_COUNT-1:0] b_mask_ff, b_mask_in;

   logic                         in_lattice, xm, ym, zm;
   logic [lspg_pkg::QCNT_W-1:0]  in_flight;
   logic [lspg_pkg::IDX_W:0]     x_term;

   assign sx = lspg_pkg::clamp_size(size_x_ff);
   assign sy = lspg_pkg::clamp_size(size_y_ff);
   assign sz = lspg_pkg::clamp_size(size_z_ff);
   assign sxy_in = lspg_pkg::SXY_W'(sy * sz);

   // queue slots in use or already promised to items in the two front stages
   assign in_flight = q_count + lspg_pkg::QCNT_W'(a_valid_ff) + lspg_pkg::QCNT_W'(b_valid_ff);
   assign req.ready = in_flight < lspg_pkg::QCNT_W'(lspg_pkg::QUEUE_DEPTH);

   always_comb begin
      in_lattice = ({1'b0, a_x_ff} < sx) && ({1'b0, a_y_ff} < sy) && ({1'b0, a_z_ff} < sz);
      xm = ({1'b0, a_x_ff} + 7'd1) != sx;
      ym = ({1'b0, a_y_ff} + 7'd1) != sy;
      zm = ({1'b0, a_z_ff} + 7'd1) != sz;
      for (int i = 0; i < lspg_pkg::SLOT_COUNT; i++) begin
         b_mask_in[i] = lspg_pkg::slot_enable(lspg_pkg::SLOT_W'(i), xm, ym, zm);
      end
      b_ysz_in   = lspg_pkg::YSZ_W'(a_y_ff * sz);
      b_valid_in = a_valid_ff & in_lattice & (|b_mask_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff  <= lspg_pkg::SIZE_W'(1);
         size_y_ff  <= lspg_pkg::SIZE_W'(1);
         size_z_ff  <= lspg_pkg::SIZE_W'(1);
         sxy_ff     <= lspg_pkg::SXY_W'(1);
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               lspg_pkg::REG_SIZE_X: size_x_ff <= csr_wr_data;
               lspg_pkg::REG_SIZE_Y: size_y_ff <= csr_wr_data;
               lspg_pkg::REG_SIZE_Z: size_z_ff <= csr_wr_data;
               default: ;
            endcase
         end
         sxy_ff     <= sxy_in;
         a_valid_ff <= req.valid & req.ready;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid & req.ready) begin
         a_x_ff <= req.node_x;
         a_y_ff <= req.node_y;
         a_z_ff <= req.node_z;
      end
      b_x_ff    <= a_x_ff;
      b_z_ff    <= a_z_ff;
      b_ysz_ff  <= b_ysz_in;
      b_sz_ff   <= sz;
      b_mask_ff <= b_mask_in;
   end

   // base = z + y*sz + x*sy*sz
   assign x_term = (lspg_pkg::IDX_W + 1)'(b_x_ff * sxy_ff);

   assign push_valid      = b_valid_ff;
   assign push_entry.base = lspg_pkg::IDX_W'(x_term) + lspg_pkg::IDX_W'(b_ysz_ff)
                          + lspg_pkg::IDX_W'(b_z_ff);
   assign push_entry.sz   = b_sz_ff;
   assign push_entry.sxy  = sxy_ff;
   assign push_entry.mask = b_mask_ff;

endmodule
`default_nettype wire

@@ rtl/lspg_queue.sv @@
// Small FIFO of classified nodes between the front and back ends.
`default_nettype none
module lspg_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire lspg_pkg::entry_type          push_entry,
   input  wire logic                         pop,
   output logic                              head_valid,
   output lspg_pkg::entry_type               head_entry,
   output logic [lspg_pkg::QCNT_W-1:0]       count
);

   lspg_pkg::entry_type               mem_ff [lspg_pkg::QUEUE_DEPTH];
   logic [lspg_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [lspg_pkg::QCNT_W-1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + lspg_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + lspg_pkg::QPTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + lspg_pkg::QCNT_W'(1);
            2'b01:   count_ff <= count_ff - lspg_pkg::QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_entry = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule
`default_nettype wire

@@ rtl/lspg_back.sv @@
// Back end: walks a node's slot mask into the result register, one pair per cycle unless stalled.
`default_nettype none
module lspg_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire lspg_pkg::entry_type   q_head,
   output logic                       pop,
   lspg_rsp_if.source                 rsp
);

   logic                            act_ff;
   lspg_pkg::entry_type             cur_ff;
   lspg_pkg::entry_type             cur;
   logic                            cur_valid, adv;
   logic [lspg_pkg::SLOT_COUNT-1:0] low_bit, next_mask;
   logic [lspg_pkg::SLOT_W-1:0]     slot;

   logic                            rsp_valid_ff;
   logic [lspg_pkg::IDX_W-1:0]      first_ff, second_ff, first_in, second_in;
   logic                            last_ff;

   assign cur       = act_ff ? cur_ff : q_head;
   assign cur_valid = act_ff | q_valid;
   assign adv       = cur_valid & (~rsp_valid_ff | rsp.ready);
   assign pop       = adv & ~act_ff;

   always_comb begin
      low_bit   = cur.mask & (~cur.mask + lspg_pkg::SLOT_COUNT'(1));
      next_mask = cur.mask & ~low_bit;
      slot      = '0;
      for (int i = 0; i < lspg_pkg::SLOT_COUNT; i++) begin
         if (low_bit[i]) begin
            slot = slot | lspg_pkg::SLOT_W'(i);
         end
      end
      first_in  = lspg_pkg::node_index(cur.base, cur.sz, cur.sxy, lspg_pkg::slot_a_off(slot));
      second_in = lspg_pkg::node_index(cur.base, cur.sz, cur.sxy, lspg_pkg::slot_b_off(slot));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            act_ff       <= |next_mask;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cur_ff.base <= cur.base;
         cur_ff.sz   <= cur.sz;
         cur_ff.sxy  <= cur.sxy;
         cur_ff.mask <= next_mask;
         first_ff    <= first_in;
         second_ff   <= second_in;
         last_ff     <= ~(|next_mask);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.first_index  = first_ff;
   assign rsp.second_index = second_ff;
   assign rsp.last_pair    = last_ff;

endmodule
`default_nettype wire

@@ tb/tb_lattice_spring_pair_generator_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the lattice spring pair generator: directed node table, then random nodes.
module tb_lattice_spring_pair_generator_top;
   import lspg_pkg::*;

   // index 3 decodes to no register; writes there must leave the sizes alone
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   // quiet cycles after the last pair before a size write or the verdict:
   // covers the two front stages, where spring-less nodes are dropped
   localparam int SETTLE_CYCLES   = 16;
   localparam int ITEMS_PER_PHASE = 26;   // nodes that yield pairs, per random phase
   localparam int PHASES          = 5;    // last phase runs with no idling at all

   typedef struct packed {
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] second_index;
      logic             last_pair;
   } spring_pair_type;

   typedef enum logic {ROW_WRITE, ROW_NODE} row_kind_type;

   // one row of the directed table: a size write or a node; a node row either
   // carries its expected pairs (none or one) or leaves them to the predictor
   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic [SIZE_W-1:0]      reg_val;
      logic [COORD_W-1:0]     x;
      logic [COORD_W-1:0]     y;
      logic [COORD_W-1:0]     z;
      bit                     known;
      int                     known_pairs;
      logic [IDX_W-1:0]       known_first;
      logic [IDX_W-1:0]       known_second;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wr_data;

   lspg_req_if req_chan();
   lspg_rsp_if rsp_chan();

   lattice_spring_pair_generator_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // bench copy of the size registers, as written
   logic [SIZE_W-1:0] span_x = 7'd1;
   logic [SIZE_W-1:0] span_y = 7'd1;
   logic [SIZE_W-1:0] span_z = 7'd1;

   spring_pair_type pair_q[$];       // pairs still owed by the DUT, oldest first
   stim_row_type    directed_rows[$];
   int           mismatch_count  = 0;
   int           gap_pct         = 0; // chance of a sender idle burst before a node
   int           stall_pct       = 0; // chance of a receiver stall burst per cycle
   int           stall_left      = 0;
   bit           nodes_since_cfg = 0;

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch @%0t: %s", $realtime, msg);
      end
   endfunction

   // sizes above MAX_SIDE behave as MAX_SIDE
   function automatic int clip_span(input logic [SIZE_W-1:0] s);
      return (s > MAX_SIDE) ? MAX_SIDE : int'(s);
   endfunction

   function automatic spring_pair_type make_pair(input int a, input int b);
      spring_pair_type p;
      p.first_index  = a[IDX_W-1:0];
      p.second_index = b[IDX_W-1:0];
      p.last_pair    = 1'b0;
      return p;
   endfunction

   // Spring list of one node under the current sizes. Appends the pairs to
   // pair_q and returns how many there are.
   function automatic int predict_springs(input logic [COORD_W-1:0] x, y, z);
      int              sx, sy, sz, sxy, base, lx, ly, lz;
      bit              xm, ym, zm;
      spring_pair_type found[$];
      sx = clip_span(span_x);
      sy = clip_span(span_y);
      sz = clip_span(span_z);
      // outside the lattice (zero sizes included): nothing
      if (x >= sx || y >= sy || z >= sz) begin
         return 0;
      end
      // an axis steps forward only off its last plane
      xm   = (x + 1 != sx);
      ym   = (y + 1 != sy);
      zm   = (z + 1 != sz);
      sxy  = sy * sz;
      base = z + y * sz + x * sxy;
      lx   = xm ? 2 : 1;
      ly   = ym ? 2 : 1;
      lz   = zm ? 2 : 1;
      // forward neighbors of the 2x2x2 cell, x outermost, z innermost
      for (int dx = 0; dx < lx; dx++) begin
         for (int dy = 0; dy < ly; dy++) begin
            for (int dz = 0; dz < lz; dz++) begin
               if (dx != 0 || dy != 0 || dz != 0) begin
                  found = {found, make_pair(base, base + dz + dy * sz + dx * sxy)};
               end
            end
         end
      end
      // cross diagonals whose first endpoint lies on the z+1 plane
      if (zm) begin
         if (ym) found = {found, make_pair(base + 1, base + sz)};
         if (xm) found = {found, make_pair(base + 1, base + sxy)};
         if (ym && xm) begin
            found = {found, make_pair(base + 1, base + sz + sxy)};
            found = {found, make_pair(base + 1 + sxy, base + sz)};
            found = {found, make_pair(base + 1 + sz, base + sxy)};
         end
      end
      // closing y/x diagonal
      if (ym && xm) found = {found, make_pair(base + sz, base + sxy)};
      if (found.size() != 0) begin
         found[found.size() - 1].last_pair = 1'b1;
      end
      foreach (found[i]) pair_q = {pair_q, found[i]};
      return found.size();
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord(input logic [SIZE_W-1:0] s);
      int e;
      e = clip_span(s);
      // lean on the last plane, where the boundary tests bite
      if ($urandom_range(99, 0) < 30) return COORD_W'(e - 1);
      return COORD_W'($urandom_range(e - 1, 0));
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [SIZE_W-1:0] val);
      stim_row_type r;
      r.kind = ROW_WRITE;
      r.reg_idx = idx;
      r.reg_val = val;
      r.x = '0; r.y = '0; r.z = '0;
      r.known = 1'b0;
      r.known_pairs = 0;
      r.known_first = '0;
      r.known_second = '0;
      directed_rows = {directed_rows, r};
   endfunction

   function automatic void add_node(input logic [COORD_W-1:0] x, y, z,
                                    input bit known, input int pairs,
                                    input logic [IDX_W-1:0] first, second);
      stim_row_type r;
      r.kind = ROW_NODE;
      r.reg_idx = REG_SIZE_X;
      r.reg_val = '0;
      r.x = x; r.y = y; r.z = z;
      r.known = known;
      r.known_pairs = pairs;
      r.known_first = first;
      r.known_second = second;
      directed_rows = {directed_rows, r};
   endfunction

   // Offer one node item; entered and left at a falling edge. Expectations are
   // queued at the accepting edge.
   task automatic send_node(input logic [COORD_W-1:0] x, y, z,
                            input bit known, input int known_pairs,
                            input logic [IDX_W-1:0] known_first, known_second,
                            output int produced);
      spring_pair_type p;
      if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.node_x <= x;
      req_chan.node_y <= y;
      req_chan.node_z <= z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (known) begin
         produced = known_pairs;
         if (known_pairs > 0) begin
            p = make_pair(known_first, known_second);
            p.last_pair = 1'b1;
            pair_q = {pair_q, p};
         end
      end else begin
         produced = predict_springs(x, y, z);
      end
      nodes_since_cfg = 1'b1;
      @(negedge clock);
   endtask

   // Size write, only with the block drained. Entered and left at a falling edge.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      if (nodes_since_cfg) begin
         req_chan.valid <= 1'b0;
         while (pair_q.size() != 0) @(negedge clock);
         // spring-less nodes leave no pair behind; let them clear the pipe
         repeat (SETTLE_CYCLES) @(negedge clock);
         nodes_since_cfg = 1'b0;
      end
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_SIZE_X: span_x = val;
         REG_SIZE_Y: span_y = val;
         REG_SIZE_Z: span_z = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Receiver: random stall bursts, otherwise ready.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(99, 0) < stall_pct) begin
         stall_left = $urandom_range(12, 1) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Pair checker: every accepted pair against the oldest owed pair.
   always @(posedge clock) begin
      spring_pair_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pair_q.size() == 0) begin
            log_mismatch($sformatf("unexpected pair %0d-%0d last=%0b",
                                   rsp_chan.first_index, rsp_chan.second_index,
                                   rsp_chan.last_pair));
         end else begin
            want = pair_q.pop_front();
            if (rsp_chan.first_index !== want.first_index) begin
               log_mismatch($sformatf("first_index exp %0d got %0d",
                                      want.first_index, rsp_chan.first_index));
            end
            if (rsp_chan.second_index !== want.second_index) begin
               log_mismatch($sformatf("second_index exp %0d got %0d",
                                      want.second_index, rsp_chan.second_index));
            end
            if (rsp_chan.last_pair !== want.last_pair) begin
               log_mismatch($sformatf("last_pair exp %0b got %0b (pair %0d-%0d)",
                                      want.last_pair, rsp_chan.last_pair,
                                      want.first_index, want.second_index));
            end
         end
      end
   end

   // Stimulus: directed table, random phases, drain, verdict.
   initial begin
      int                 produced;
      int                 productive;
      logic [SIZE_W-1:0]  sx, sy, sz;
      logic [COORD_W-1:0] nx, ny, nz;

      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = REG_SIZE_X;
      csr_wr_data     = '0;
      req_chan.valid  = 1'b0;
      req_chan.node_x = '0;
      req_chan.node_y = '0;
      req_chan.node_z = '0;
      rsp_chan.ready  = 1'b0;

      // sizes out of reset are 1x1x1: the lone node owns no spring
      add_node(0, 0, 0, 1, 0, 0, 0);
      add_node(63, 63, 63, 1, 0, 0, 0);        // far outside
      // 2x1x1: single x spring
      add_write(REG_SIZE_X, 2);
      add_node(0, 0, 0, 1, 1, 0, 1);
      add_node(1, 0, 0, 1, 0, 0, 0);           // last node owns nothing
      // 1x1x2: single z spring
      add_write(REG_SIZE_X, 1);
      add_write(REG_SIZE_Z, 2);
      add_node(0, 0, 0, 1, 1, 0, 1);
      // 2x2x2: full 13-pair corner, partial faces and edges
      add_write(REG_SIZE_Y, 2);
      add_write(REG_SIZE_X, 2);
      add_node(0, 0, 0, 0, 0, 0, 0);
      add_node(1, 1, 1, 1, 0, 0, 0);
      add_node(0, 1, 0, 0, 0, 0, 0);
      add_node(1, 0, 1, 0, 0, 0, 0);
      add_node(0, 0, 1, 0, 0, 0, 0);
      // all-ones sizes clip to 64 on every axis
      add_write(REG_SIZE_X, 127);
      add_write(REG_SIZE_Y, 127);
      add_write(REG_SIZE_Z, 127);
      // top of the index range: (63,63,62) is 262142, its z neighbor 262143
      add_node(63, 63, 62, 1, 1, 262142, 262143);
      add_node(63, 63, 63, 1, 0, 0, 0);
      add_node(0, 0, 0, 0, 0, 0, 0);
      add_node(62, 62, 62, 0, 0, 0, 0);
      add_node(42, 21, 10, 0, 0, 0, 0);
      // exactly 64 on every axis
      add_write(REG_SIZE_X, 64);
      add_write(REG_SIZE_Y, 64);
      add_write(REG_SIZE_Z, 64);
      add_node(62, 63, 0, 0, 0, 0, 0);
      add_node(0, 62, 63, 0, 0, 0, 0);
      // write to the unused index is dropped
      add_write(REG_UNUSED, 7'h55);
      add_node(1, 1, 1, 0, 0, 0, 0);
      // a zero size on any axis empties the lattice
      add_write(REG_SIZE_Z, 0);
      add_node(0, 0, 0, 1, 0, 0, 0);
      add_write(REG_SIZE_X, 0);
      add_write(REG_SIZE_Z, 3);
      add_node(0, 0, 0, 1, 0, 0, 0);
      add_write(REG_SIZE_Y, 0);
      add_write(REG_SIZE_X, 3);
      add_node(0, 0, 0, 1, 0, 0, 0);

      // reset held high from the start, released at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      gap_pct   = 25;
      stall_pct = 25;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            csr_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
         end else begin
            send_node(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                      directed_rows[i].known, directed_rows[i].known_pairs,
                      directed_rows[i].known_first, directed_rows[i].known_second,
                      produced);
         end
      end

      // Random phases: a fresh lattice shape and idle mix each time. Most
      // nodes fall inside the lattice; the rest are arbitrary coordinates.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               sx = SIZE_W'($urandom_range(4, 2));
               sy = SIZE_W'($urandom_range(4, 1));
               sz = SIZE_W'($urandom_range(4, 1));
               gap_pct = 30; stall_pct = 30;
            end
            1: begin
               sx = SIZE_W'($urandom_range(8, 2));
               sy = SIZE_W'($urandom_range(8, 1));
               sz = SIZE_W'($urandom_range(8, 1));
               gap_pct = 0; stall_pct = 45;
            end
            2: begin
               // long z axis, possibly past the clip point
               sx = SIZE_W'($urandom_range(3, 1));
               sy = SIZE_W'($urandom_range(3, 1));
               sz = SIZE_W'($urandom_range(127, 64));
               gap_pct = 45; stall_pct = 0;
            end
            3: begin
               sx = SIZE_W'($urandom_range(4, 1));
               sy = SIZE_W'($urandom_range(64, 2));
               sz = SIZE_W'($urandom_range(4, 1));
               gap_pct = 20; stall_pct = 20;
            end
            default: begin
               // closing stretch at full rate
               sx = SIZE_W'($urandom_range(5, 2));
               sy = SIZE_W'($urandom_range(5, 2));
               sz = SIZE_W'($urandom_range(5, 2));
               gap_pct = 0; stall_pct = 0;
            end
         endcase
         csr_write(REG_SIZE_X, sx);
         csr_write(REG_SIZE_Y, sy);
         csr_write(REG_SIZE_Z, sz);
         productive = 0;
         while (productive < ITEMS_PER_PHASE) begin
            if ($urandom_range(99, 0) < 15) begin
               nx = COORD_W'($urandom_range(63, 0));
               ny = COORD_W'($urandom_range(63, 0));
               nz = COORD_W'($urandom_range(63, 0));
            end else begin
               nx = pick_coord(span_x);
               ny = pick_coord(span_y);
               nz = pick_coord(span_z);
            end
            send_node(nx, ny, nz, 1'b0, 0, '0, '0, produced);
            if (produced > 0) productive++;
         end
      end

      req_chan.valid <= 1'b0;
      while (pair_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS lattice_spring_pair_generator_top");
      end else begin
         $display("FAIL lattice_spring_pair_generator_top");
      end
      $finish;
   end

   // Watchdog: ends the run with FAIL if the stimulus hangs.
   initial begin
      #5_000_000;
      $display("FAIL lattice_spring_pair_generator_top");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/lspg_pkg.sv
rtl/lspg_if.sv
rtl/lspg_front.sv
rtl/lspg_queue.sv
rtl/lspg_back.sv
rtl/lattice_spring_pair_generator_top.sv
tb/tb_lattice_spring_pair_generator_top.sv
